// File: src/svps_pkg.sv
// Shared types, opcodes and constants of the servo pulse sequencer.
// Used by the register block, the step engine and the top level.
// Depends on nothing else.
package svps_pkg;

    // Item opcodes (codes above OP_DISABLE change nothing)
    localparam logic [2:0] OP_TICK     = 3'd0;
    localparam logic [2:0] OP_SET_POS  = 3'd1;
    localparam logic [2:0] OP_SET_TRIM = 3'd2;
    localparam logic [2:0] OP_ENABLE   = 3'd3;
    localparam logic [2:0] OP_DISABLE  = 3'd4;

    // Register select, taken from paddr[2]
    localparam logic REG_BASE_PERIOD  = 1'b0;
    localparam logic REG_FRAME_PERIOD = 1'b1;

    // Reset values
    localparam logic [7:0]  BASE_PERIOD_RST  = 8'd124;
    localparam logic [15:0] FRAME_PERIOD_RST = 16'd625;
    localparam logic [7:0]  POS_RST          = 8'd128;
    localparam logic [7:0]  TRIM_RST         = 8'd64;

    // Pulse length arithmetic
    localparam logic [9:0] TRIM_ZERO = 10'd64;
    localparam logic [9:0] LEN_TOP   = 10'd319;  // TRIM_ZERO + 255
    localparam logic [7:0] LEN_MAX   = 8'd255;

    // Input item, opcode in the low bits
    typedef struct packed {
        logic [7:0] data_byte;
        logic [1:0] channel;
        logic [2:0] opcode;
    } t_item;

    // Result item, servo_lines in the low bits
    typedef struct packed {
        logic [1:0] active_channel;
        logic       pulse_busy;
        logic       running;
        logic [3:0] servo_lines;
    } t_result;

    // Configuration registers as seen by the engine
    typedef struct packed {
        logic [15:0] frame_period;
        logic [7:0]  base_period;
    } t_cfg;

    // Pulse length: base + trim/2 + pos/2 - 64, out of range gives 255
    function automatic logic [7:0] pulse_len(input logic [7:0] base,
                                             input logic [7:0] trim,
                                             input logic [7:0] pos);
        logic [9:0] sum;
        logic [9:0] diff;
        sum  = {2'b00, base} + {3'b000, trim[7:1]} + {3'b000, pos[7:1]};
        diff = sum - TRIM_ZERO;
        if ((sum < TRIM_ZERO) || (sum > LEN_TOP)) begin
            return LEN_MAX;
        end
        return diff[7:0];
    endfunction

endpackage

// File: src/servo_pulse_sequencer_core.sv
// An accepted item is held in the input register and its result in the result register.
// Throughput: one item per cycle while results are not stalled; the step engine
// applies each item combinationally between the input and result registers.
// While a result item is stalled the input register takes one more item, then stalls.
// Reset (i_rst_n low, synchronous) empties both registers and loads the register
// and channel table reset values; there is no clearing pass.
module servo_pulse_sequencer_core #(
    parameter int CHANNELS = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Item stream in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // opcode[2:0], channel[4:3], data_byte[12:5]
    // Result stream out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // servo_lines[3:0], running[4], pulse_busy[5],
                                        // active_channel[7:6]
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import svps_pkg::*;

    logic    r_in_vld;
    t_item   r_in_item;
    logic    r_out_vld;
    t_result r_out_res;
    logic    w_step;
    t_result w_res;
    t_cfg    w_cfg;

    // Step when an item waits and the result register can take its result
    assign w_step        = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || w_step;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_vld <= 1'b1;
        end else if (w_step) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item <= t_item'(s_axis_tdata[12:0]);
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_step) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_step) begin
            r_out_res <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_res;

    svps_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    svps_engine #(
        .CHANNELS (CHANNELS)
    ) u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_step),
        .i_item   (r_in_item),
        .i_cfg    (w_cfg),
        .o_result (w_res)
    );

endmodule

// File: src/svps_apb_regs.sv
// APB register block: base_period at 0x0, frame_period at 0x4.
// Depends on svps_pkg for the register select codes and the config struct.
module svps_apb_regs (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [2:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output svps_pkg::t_cfg    o_cfg
);
    import svps_pkg::*;

    logic [7:0]  r_base_period;
    logic [15:0] r_frame_period;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;

    // Write registers on the access cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base_period  <= BASE_PERIOD_RST;
            r_frame_period <= FRAME_PERIOD_RST;
        end else if (w_wr) begin
            unique case (paddr[2])
                REG_BASE_PERIOD:  r_base_period  <= pwdata[7:0];
                REG_FRAME_PERIOD: r_frame_period <= pwdata[15:0];
                default:          ;
            endcase
        end
    end

    // Read back the selected register
    always_comb begin
        unique case (paddr[2])
            REG_BASE_PERIOD:  prdata = {24'd0, r_base_period};
            REG_FRAME_PERIOD: prdata = {16'd0, r_frame_period};
            default:          prdata = 32'd0;
        endcase
    end

    assign o_cfg.base_period  = r_base_period;
    assign o_cfg.frame_period = r_frame_period;

endmodule

// File: src/svps_engine.sv
// Step engine: channel tables, pulse timer, frame timer and channel rotation.
// Applies one item per step and presents the state after it as a result.
// Depends on svps_pkg for opcodes, item and result structs and pulse_len.
module svps_engine #(
    parameter int CHANNELS = 4
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  svps_pkg::t_item    i_item,
    input  svps_pkg::t_cfg     i_cfg,
    output svps_pkg::t_result  o_result
);
    import svps_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Channel tables
    logic [7:0]      r_pos  [CHANNELS];
    logic [7:0]      r_trim [CHANNELS];

    // Sequencer state
    logic [CH_W-1:0] r_cur,   w_mid_cur;
    logic            r_on,    w_mid_on,    n_on;
    logic [7:0]      r_ticks, w_mid_ticks, n_ticks;
    logic [7:0]      r_len,   n_len;
    logic [15:0]     r_ft,    w_mid_ft,    n_ft;
    logic            r_fe,    w_mid_fe;
    logic            r_ew,    w_mid_ew;

    logic            w_is_tick;
    logic            w_ch_ok;
    logic [4:0]      w_ch_ext;
    logic [CH_W:0]   w_cur_inc;
    logic [CH_W-1:0] w_cur_rot;
    logic [7:0]      w_new_len;
    logic [16:0]     w_ft_next;
    logic [16:0]     w_period;
    logic [CH_W+1:0] w_cur_ext;
    logic [3:0]      w_lines;

    assign w_is_tick = (i_item.opcode == OP_TICK);
    assign w_ch_ext  = {3'b000, i_item.channel};
    assign w_ch_ok   = (w_ch_ext < 5'(CHANNELS));

    // Next channel in rotation
    assign w_cur_inc = {1'b0, r_cur} + (CH_W+1)'(1);
    assign w_cur_rot = (w_cur_inc >= (CH_W+1)'(CHANNELS)) ? '0 : w_cur_inc[CH_W-1:0];

    // Time the running pulse and apply the enable and disable opcodes
    always_comb begin
        w_mid_on    = r_on;
        w_mid_ticks = r_ticks;
        w_mid_cur   = r_cur;
        w_mid_ft    = r_ft;
        w_mid_fe    = r_fe;
        w_mid_ew    = r_ew;
        unique case (i_item.opcode)
            OP_TICK: begin
                if (r_on) begin
                    if (r_ticks == r_len) begin
                        w_mid_on    = 1'b0;
                        w_mid_ticks = 8'd0;
                        w_mid_cur   = w_cur_rot;
                        if (r_ew) begin
                            w_mid_ew  = 1'b0;
                            w_mid_cur = '0;
                            w_mid_ft  = 16'd0;
                            w_mid_fe  = 1'b1;
                        end
                    end else begin
                        w_mid_ticks = r_ticks + 8'd1;
                    end
                end
            end
            OP_ENABLE: begin
                if (!r_fe) begin
                    if (r_on) begin
                        w_mid_ew = 1'b1;
                    end else begin
                        w_mid_cur = '0;
                        w_mid_ft  = 16'd0;
                        w_mid_fe  = 1'b1;
                    end
                end
            end
            OP_DISABLE: begin
                w_mid_fe = 1'b0;
                w_mid_ew = 1'b0;
            end
            default: ;
        endcase
    end

    // Length of a pulse started on the channel left by pulse timing
    assign w_new_len = pulse_len(i_cfg.base_period, r_trim[w_mid_cur], r_pos[w_mid_cur]);

    // Frame timer; a zero period counts 65536 ticks
    assign w_ft_next = {1'b0, w_mid_ft} + 17'd1;
    assign w_period  = (i_cfg.frame_period == 16'd0) ? 17'h10000
                                                     : {1'b0, i_cfg.frame_period};

    always_comb begin
        n_on    = w_mid_on;
        n_ticks = w_mid_ticks;
        n_len   = r_len;
        n_ft    = w_mid_ft;
        if (w_is_tick && w_mid_fe) begin
            if (w_ft_next >= w_period) begin
                n_ft    = 16'd0;
                n_len   = w_new_len;
                n_ticks = 8'd0;
                n_on    = 1'b1;
            end else begin
                n_ft = w_ft_next[15:0];
            end
        end
    end

    // Hold state, advance on each step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur   <= '0;
            r_on    <= 1'b0;
            r_ticks <= 8'd0;
            r_len   <= 8'd0;
            r_ft    <= 16'd0;
            r_fe    <= 1'b0;
            r_ew    <= 1'b0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_pos[i]  <= POS_RST;
                r_trim[i] <= TRIM_RST;
            end
        end else if (i_step) begin
            r_cur   <= w_mid_cur;
            r_on    <= n_on;
            r_ticks <= n_ticks;
            r_len   <= n_len;
            r_ft    <= n_ft;
            r_fe    <= w_mid_fe;
            r_ew    <= w_mid_ew;
            for (int i = 0; i < CHANNELS; i++) begin
                if (w_ch_ok && (w_ch_ext == 5'(i))) begin
                    if (i_item.opcode == OP_SET_POS) begin
                        r_pos[i] <= i_item.data_byte;
                    end
                    if (i_item.opcode == OP_SET_TRIM) begin
                        r_trim[i] <= i_item.data_byte;
                    end
                end
            end
        end
    end

    // Report the state after the item
    assign w_cur_ext = {2'b00, w_mid_cur};

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            w_lines[i] = n_on && (w_cur_ext == (CH_W+2)'(i));
        end
    end

    assign o_result.servo_lines    = w_lines;
    assign o_result.running        = w_mid_fe;
    assign o_result.pulse_busy     = n_on;
    assign o_result.active_channel = w_cur_ext[1:0];

endmodule

// File: src/svps_checker.sv
// Port-level checks for the servo pulse sequencer, attached by bind.
// Depends only on the top level's ports.
module svps_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata
);

    // At most one servo line is high
    a_one_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> $onehot0(m_axis_tdata[3:0]))
        else $error("more than one servo line high");

    // A high line means a pulse is being timed
    a_line_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[3:0] != 4'd0)) |-> m_axis_tdata[5])
        else $error("servo line high without a pulse");

    // A stalled result item holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("stalled result item changed");

    // Reset empties the result register
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

endmodule

bind servo_pulse_sequencer_core svps_checker u_svps_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// File: verif/servo_pulse_sequencer_core_tb.sv
`timescale 1ns / 1ps
// Testbench for servo_pulse_sequencer_core: a directed table, then random item phases under
// several register settings, each result checked field by field vs a pinned or model value.
// Depends on svps_pkg and the servo_pulse_sequencer_core RTL.
module servo_pulse_sequencer_core_tb;
    import svps_pkg::*;

    // Opcodes above OP_DISABLE only report the state
    localparam logic [2:0] OP_SPARE_LO  = 3'd5;
    localparam logic [2:0] OP_SPARE_MID = 3'd6;
    localparam logic [2:0] OP_SPARE_HI  = 3'd7;

    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 91;
    localparam int HOLD_PHASE      = 3;
    localparam int HOLD_CYCLES     = 300;
    localparam int MAX_GAP         = 17;
    localparam int STALL_LIMIT     = 2000;
    localparam int MAX_REPORTS     = 10;

    // Results that follow directly from the opcode sequence
    localparam t_result RES_IDLE       = t_result'(8'h00);  // nothing running, channel 0
    localparam t_result RES_RUNNING    = t_result'(8'h10);  // frames on, channel 0
    localparam t_result RES_PULSE_CH0  = t_result'(8'h31);  // frames on, line 0 high
    localparam t_result RES_DRAIN_CH0  = t_result'(8'h21);  // frames off, line 0 finishing

    // One line of the directed table: an item or a register write
    typedef struct packed {
        logic        is_cfg;
        logic        reg_sel;
        logic [31:0] value;
        t_item       item;
        logic        pinned;
        t_result     pinned_res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = 16'd0;   // opcode[2:0], channel[4:3], data_byte[12:5]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;           // servo_lines[3:0], running[4], pulse_busy[5],
                                         // active_channel[7:6]
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = 3'd0;
    logic [31:0] pwdata = 32'd0;
    logic [31:0] prdata;
    logic        pready;

    // Model state: registers, channel tables and pulse/frame timing
    logic [7:0]  base_cfg = BASE_PERIOD_RST;
    logic [15:0] frame_cfg = FRAME_PERIOD_RST;
    logic [7:0]  pos_tab [4] = '{POS_RST, POS_RST, POS_RST, POS_RST};
    logic [7:0]  trim_tab [4] = '{TRIM_RST, TRIM_RST, TRIM_RST, TRIM_RST};
    logic [1:0]  cur_ch = 2'd0;
    logic        pulse_on = 1'b0;
    logic [7:0]  pulse_cnt = 8'd0;
    logic [7:0]  pulse_len = 8'd0;
    logic [15:0] frame_cnt = 16'd0;
    logic        frames_on = 1'b0;
    logic        enable_pending = 1'b0;

    t_row        script [$];
    t_result     expected_res [$];
    logic        pin_valid = 1'b0;
    t_result     pin_value = RES_IDLE;
    t_result     model_res;
    t_result     seen_res;
    t_result     want_res;
    logic        moved;
    int          idle_cycles = 0;
    int          fail_count = 0;
    logic        send_quiet = 1'b0;
    logic        recv_quiet = 1'b0;
    logic        hold_req = 1'b0;

    int phase_base [NUM_PHASES]  = '{0, 70, 255, 80, 124, 64, 255, 75};
    int phase_frame [NUM_PHASES] = '{1, 40, 65535, 60, 0, 25, 1, 300};

    servo_pulse_sequencer_core #(
        .CHANNELS(4)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Apply one item to the model and return the state it reports
    function automatic t_result step_model(input t_item it);
        t_result r;
        int      len;
        int      period;
        int      next_cnt;
        case (it.opcode)
            OP_TICK: begin
                // time the running pulse first
                if (pulse_on) begin
                    if (pulse_cnt == pulse_len) begin
                        pulse_on  = 1'b0;
                        pulse_cnt = 8'd0;
                        cur_ch    = cur_ch + 2'd1;  // four channels wrap in two bits
                        if (enable_pending) begin
                            enable_pending = 1'b0;
                            cur_ch    = 2'd0;
                            frame_cnt = 16'd0;
                            frames_on = 1'b1;
                        end
                    end else begin
                        pulse_cnt = pulse_cnt + 8'd1;
                    end
                end
                // then advance the frame timer, a zero period means 65536 ticks
                if (frames_on) begin
                    period   = (frame_cfg == 16'd0) ? 65536 : int'(frame_cfg);
                    next_cnt = int'(frame_cnt) + 1;
                    if (next_cnt >= period) begin
                        frame_cnt = 16'd0;
                        len = int'(base_cfg) - int'(TRIM_ZERO)
                            + int'(trim_tab[cur_ch] >> 1) + int'(pos_tab[cur_ch] >> 1);
                        if (len < 0 || len > int'(LEN_MAX)) begin
                            len = int'(LEN_MAX);
                        end
                        pulse_len = len[7:0];
                        pulse_cnt = 8'd0;
                        pulse_on  = 1'b1;
                    end else begin
                        frame_cnt = next_cnt[15:0];
                    end
                end
            end
            OP_SET_POS: begin
                pos_tab[it.channel] = it.data_byte;
            end
            OP_SET_TRIM: begin
                trim_tab[it.channel] = it.data_byte;
            end
            OP_ENABLE: begin
                // hold the enable back while a pulse runs
                if (!frames_on) begin
                    if (pulse_on) begin
                        enable_pending = 1'b1;
                    end else begin
                        cur_ch    = 2'd0;
                        frame_cnt = 16'd0;
                        frames_on = 1'b1;
                    end
                end
            end
            OP_DISABLE: begin
                frames_on      = 1'b0;
                enable_pending = 1'b0;
            end
            default: begin
            end
        endcase
        r.servo_lines    = pulse_on ? (4'b0001 << cur_ch) : 4'b0000;
        r.running        = frames_on;
        r.pulse_busy     = pulse_on;
        r.active_channel = cur_ch;
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] seen);
        fail_count++;
        if (fail_count <= MAX_REPORTS) begin
            $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h",
                     $time, what, want, seen);
        end
    endtask

    function automatic void add_item(input logic [2:0] op, input logic [1:0] ch,
                                     input logic [7:0] data, input logic pin,
                                     input t_result res);
        t_row row;
        row = '0;
        row.item.opcode    = op;
        row.item.channel   = ch;
        row.item.data_byte = data;
        row.pinned         = pin;
        row.pinned_res     = res;
        script.push_back(row);
    endfunction

    function automatic void add_cfg(input logic sel, input logic [31:0] value);
        t_row row;
        row = '0;
        row.is_cfg  = 1'b1;
        row.reg_sel = sel;
        row.value   = value;
        script.push_back(row);
    endfunction

    // Offer one item after a random gap, or none when send_quiet, and hold it until accepted
    task automatic send_item(input t_item it, input logic pin, input t_result pin_val);
        int gap;
        gap = send_quiet ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        pin_valid = pin;
        pin_value = pin_val;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, it};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    // Drop the input and wait for every outstanding result
    task automatic wait_results_done();
        s_axis_tvalid <= 1'b0;
        while (expected_res.size() != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Write a register, read it back and update the model
    task automatic write_reg(input logic sel, input logic [31:0] value);
        logic [31:0] width_mask;
        width_mask = (sel == REG_BASE_PERIOD) ? 32'h0000_00FF : 32'h0000_FFFF;
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {sel, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== (value & width_mask)) begin
            report_mismatch("register read-back", value & width_mask, prdata);
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (sel == REG_BASE_PERIOD) begin
            base_cfg = value[7:0];
        end else begin
            frame_cfg = value[15:0];
        end
        // leave the bus idle before the next transfer
        @(negedge i_clk);
    endtask

    // Predict on each accepted input item, check each accepted result item
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            moved = 1'b0;
            if (s_axis_tvalid && s_axis_tready) begin
                model_res = step_model(t_item'(s_axis_tdata[12:0]));
                expected_res.push_back(pin_valid ? pin_value : model_res);
                moved = 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                moved    = 1'b1;
                seen_res = t_result'(m_axis_tdata);
                if (expected_res.size() == 0) begin
                    report_mismatch("unexpected result", 32'd0, 32'(seen_res));
                end else begin
                    want_res = expected_res.pop_front();
                    if (seen_res.servo_lines !== want_res.servo_lines) begin
                        report_mismatch("servo_lines", 32'(want_res.servo_lines),
                                        32'(seen_res.servo_lines));
                    end
                    if (seen_res.running !== want_res.running) begin
                        report_mismatch("running", 32'(want_res.running),
                                        32'(seen_res.running));
                    end
                    if (seen_res.pulse_busy !== want_res.pulse_busy) begin
                        report_mismatch("pulse_busy", 32'(want_res.pulse_busy),
                                        32'(seen_res.pulse_busy));
                    end
                    if (seen_res.active_channel !== want_res.active_channel) begin
                        report_mismatch("active_channel", 32'(want_res.active_channel),
                                        32'(seen_res.active_channel));
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    // Stall the result side at random, or not when recv_quiet, with one long hold-off on request
    initial begin : result_sink
        int gap;
        wait (i_rst_n === 1'b1);
        @(negedge i_clk);
        forever begin
            if (hold_req) begin
                gap      = HOLD_CYCLES;
                hold_req = 1'b0;
            end else begin
                gap = recv_quiet ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
            @(negedge i_clk);
        end
    end

    // End the run when nothing moves for too long
    initial begin : watchdog
        while (idle_cycles < STALL_LIMIT) @(negedge i_clk);
        $display("servo_pulse_sequencer_core test failed");
        $finish;
    end

    initial begin : stimulus
        t_item it;
        int    pick;

        // Idle block after reset: every op reports the reset state
        add_item(OP_TICK, 2'd0, 8'h00, 1'b1, RES_IDLE);
        add_item(OP_SET_POS, 2'd3, 8'hFF, 1'b1, RES_IDLE);
        add_item(OP_SET_TRIM, 2'd0, 8'h00, 1'b1, RES_IDLE);
        add_item(OP_SET_POS, 2'd0, 8'h00, 1'b1, RES_IDLE);
        add_item(OP_SPARE_LO, 2'd2, 8'hAA, 1'b1, RES_IDLE);
        add_item(OP_SPARE_MID, 2'd1, 8'h55, 1'b1, RES_IDLE);
        add_item(OP_SPARE_HI, 2'd3, 8'hFF, 1'b1, RES_IDLE);
        add_item(OP_DISABLE, 2'd0, 8'h00, 1'b1, RES_IDLE);
        add_item(OP_SET_TRIM, 2'd1, 8'hFF, 1'b1, RES_IDLE);
        add_item(OP_SET_POS, 2'd1, 8'hFF, 1'b1, RES_IDLE);
        // Zero base with zero trim and position goes negative and saturates
        add_cfg(REG_BASE_PERIOD, 32'd0);
        add_cfg(REG_FRAME_PERIOD, 32'd2);
        // Enable, then a second enable while running is ignored
        add_item(OP_ENABLE, 2'd0, 8'h00, 1'b1, RES_RUNNING);
        add_item(OP_ENABLE, 2'd0, 8'h00, 1'b1, RES_RUNNING);
        add_item(OP_TICK, 2'd0, 8'h00, 1'b1, RES_RUNNING);
        add_item(OP_TICK, 2'd0, 8'h00, 1'b1, RES_PULSE_CH0);
        add_item(OP_TICK, 2'd0, 8'h00, 1'b1, RES_PULSE_CH0);
        // Frame event while the pulse runs restarts it on the same channel
        add_item(OP_TICK, 2'd0, 8'h00, 1'b1, RES_PULSE_CH0);
        // Disable lets the pulse finish; enables during the pulse wait
        add_item(OP_DISABLE, 2'd0, 8'h00, 1'b1, RES_DRAIN_CH0);
        add_item(OP_ENABLE, 2'd0, 8'h00, 1'b1, RES_DRAIN_CH0);
        add_item(OP_ENABLE, 2'd0, 8'h00, 1'b1, RES_DRAIN_CH0);
        add_item(OP_DISABLE, 2'd0, 8'h00, 1'b1, RES_DRAIN_CH0);
        add_item(OP_ENABLE, 2'd0, 8'h00, 1'b1, RES_DRAIN_CH0);
        add_item(OP_SET_TRIM, 2'd2, 8'hFF, 1'b0, RES_IDLE);
        add_item(OP_SET_POS, 2'd2, 8'h80, 1'b0, RES_IDLE);

        // Hold reset, then release it
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Walk the directed table
        for (int k = 0; k < script.size(); k++) begin
            if (script[k].is_cfg) begin
                wait_results_done();
                write_reg(script[k].reg_sel, script[k].value);
            end else begin
                send_item(script[k].item, script[k].pinned, script[k].pinned_res);
            end
        end

        // Random phases, each under its own register setting and idling pattern
        for (int p = 0; p < NUM_PHASES; p++) begin
            wait_results_done();
            write_reg(REG_BASE_PERIOD, phase_base[p]);
            write_reg(REG_FRAME_PERIOD, phase_frame[p]);
            send_quiet = (p % 3 == 1);
            recv_quiet = (p % 3 == 2);
            if (p == HOLD_PHASE) begin
                hold_req = 1'b1;
            end
            repeat (ITEMS_PER_PHASE) begin
                pick = $urandom_range(0, 99);
                if (pick < 58) begin
                    it.opcode = OP_TICK;
                end else if (pick < 70) begin
                    it.opcode = OP_SET_POS;
                end else if (pick < 82) begin
                    it.opcode = OP_SET_TRIM;
                end else if (pick < 90) begin
                    it.opcode = OP_ENABLE;
                end else if (pick < 96) begin
                    it.opcode = OP_DISABLE;
                end else begin
                    it.opcode = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
                end
                it.channel = 2'($urandom_range(0, 3));
                // Favor small bytes so pulses stay short enough to end
                it.data_byte = ($urandom_range(0, 9) < 7) ? 8'($urandom_range(0, 31))
                                                         : 8'($urandom_range(0, 255));
                send_item(it, 1'b0, RES_IDLE);
            end
        end

        wait_results_done();
        repeat (10) @(posedge i_clk);
        if (expected_res.size() != 0) begin
            report_mismatch("missing results", 32'd0, 32'(expected_res.size()));
        end
        if (fail_count == 0) begin
            $display("servo_pulse_sequencer_core test passed");
        end else begin
            $display("servo_pulse_sequencer_core test failed");
        end
        $finish;
    end

endmodule
